[rtl/pcht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcht_pkg
// Shared types and constants for the path coverage hit test unit.
// ----------------------------------------------------------------------------
package pcht_pkg;

  // Width of the internal coordinate and product arithmetic.
  localparam int ARITH_W = 64;

  typedef enum logic [1:0] {
    MD_MUL,
    MD_DIVF,
    MD_DIVT
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_ctrl_t;

  typedef struct packed {
    logic                      done;
    logic signed [ARITH_W-1:0] result;
  } md_stat_t;

endpackage

[rtl/path_coverage_hit_test_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_coverage_hit_test_unit
// Nonzero-winding hit test of a path of line edges against a clip rectangle.
// ----------------------------------------------------------------------------
// The unit takes one path command per request on the slave stream: move to,
// line to, close contour and run test. Every line edge is clipped to the
// clip rectangle and stepped one pixel row at a time; each covered row
// stores a packed atom (row, column, winding) in an on-chip atom store of
// MAX_ATOMS entries. A run test heap-sorts the store, walks every row summing
// the winding from left to right, and returns one result request carrying
// the hit flag and the overflow flag. The store is emptied after each test;
// the clip registers keep their values.
//
// Flow: the unit handles one command at a time and drops s_axis_tready
// while it works. A line or close runs the shared multiply/divide unit for
// each clip crossing and each emitted segment, and stores one atom per
// covered row. A test heap-sorts in the single atom store, which has one
// write port. There is no clearing pass after reset. A finished result
// sits in an output register, so the next command is taken while the
// result waits for m_axis_tready, unless a second test finishes before the
// first result has been taken.
// ----------------------------------------------------------------------------
module path_coverage_hit_test_unit
  import pcht_pkg::*;
#(
  parameter int MAX_ATOMS = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Command stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // pos_x [23:0], pos_y [47:24]
  input  logic [1:0]  s_axis_tuser,   // cmd [1:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // hit [0], overflow [1], zero [7:2]
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AIW = $clog2(MAX_ATOMS);
  localparam int CW  = AIW + 1;

  localparam logic signed [ARITH_W-1:0] ONE_PX    = ARITH_W'(1) << FRAC_BITS;
  localparam logic signed [ARITH_W-1:0] HALF_PX   = ONE_PX >>> 1;
  localparam logic signed [ARITH_W-1:0] XQ_HALF   = ARITH_W'(32768);
  localparam logic signed [ARITH_W-1:0] SLOPE_MAX = ARITH_W'(32'h7FFF_FFFF);
  localparam logic signed [ARITH_W-1:0] SLOPE_MIN = -SLOPE_MAX - ARITH_W'(1);
  localparam logic [CW-1:0]             FULL      = CW'(MAX_ATOMS);

  typedef enum logic [1:0] {
    CMD_MOVE,
    CMD_LINE,
    CMD_CLOSE,
    CMD_TEST
  } cmd_t;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT,
    REG_CLIP_RIGHT,
    REG_CLIP_TOP,
    REG_CLIP_BOTTOM
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    A_ORDER, A_VCHK, A_TMUL, A_TDIV, A_BMUL, A_BDIV, A_COMMIT,
    A_XORD, A_HCHK, A_LMUL, A_LDIV, A_LPOST, A_RCHK, A_RMUL, A_RDIV, A_RPOST,
    M_START, M_SLOPE, M_FACT, M_PROD, M_ROW,
    S_BLOOP, S_BRD, S_SIFT, S_SRD, S_XLOOP, S_XRD, S_SCAN, S_SCN2, S_DONE
  } state_t;

  // Configuration.
  logic [14:0] clip_left;
  logic [14:0] clip_right;
  logic [15:0] clip_top;
  logic [15:0] clip_bottom;

  // Path state.
  logic signed [23:0] first_px, first_py, prev_px, prev_py;
  logic               awaiting_move;
  logic [CW-1:0]      count;
  logic               ovf;

  state_t state, ret;

  // Edge and segment registers.
  logic signed [ARITH_W-1:0] x0, y0, x1, y1, nx0, nx1, ys;
  logic signed [ARITH_W-1:0] ax0, ay0, ax1, ay1;
  logic signed [ARITH_W-1:0] top_row, bot_row, xq;
  logic signed [31:0]        slope;
  logic                      wpos;

  // Shared unit interface.
  md_ctrl_t                  md_ctrl;
  md_stat_t                  md_stat;
  logic signed [ARITH_W-1:0] md_a, md_b, md_res;

  // Sort and scan registers.
  logic [CW-1:0]      hk, hn, si;
  logic [CW:0]        sc;
  logic [31:0]        sv;
  logic               have_row;
  logic [15:0]        scan_row;
  logic signed [CW:0] wsum;
  logic [14:0]        left_col;
  logic               hit_flag;

  // Output register.
  logic m_valid, m_hit, m_ovf;

  // Atom store.
  logic [31:0]    atom_mem [MAX_ATOMS];
  logic           wr_en;
  logic [AIW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [31:0]    wr_data, rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (wr_en) atom_mem[wr_addr] <= wr_data;
    rd_a <= atom_mem[rd_addr_a];
    rd_b <= atom_mem[rd_addr_b];
  end

  pcht_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .ctrl (md_ctrl),
    .a    (md_a),
    .b    (md_b),
    .stat (md_stat)
  );

  assign md_res = md_stat.result;

  // Clip limits in coordinate units; an inverted horizontal clip collapses
  // onto its left edge.
  logic [14:0]               rgt;
  logic signed [ARITH_W-1:0] lim_l, lim_r, lim_t, lim_b, lo_w, hi_w;

  assign rgt   = (clip_right < clip_left) ? clip_left : clip_right;
  assign lo_w  = ARITH_W'(clip_left);
  assign hi_w  = ARITH_W'(rgt);
  assign lim_l = lo_w << FRAC_BITS;
  assign lim_r = hi_w << FRAC_BITS;
  assign lim_t = ARITH_W'(clip_top) << FRAC_BITS;
  assign lim_b = ARITH_W'(clip_bottom) << FRAC_BITS;

  // Segment rows and column stepping.
  logic signed [ARITH_W-1:0] rt, rb, col, slope_ext;
  logic [14:0]               col_c;
  logic [31:0]               atom_new;

  assign rt        = (ay0 + HALF_PX) >>> FRAC_BITS;
  assign rb        = (ay1 + HALF_PX) >>> FRAC_BITS;
  assign slope_ext = ARITH_W'(slope);
  assign col       = xq >>> 16;

  always_comb begin
    if (col < lo_w) begin
      col_c = clip_left;
    end else if (col > hi_w) begin
      col_c = rgt;
    end else begin
      col_c = col[14:0];
    end
  end

  assign atom_new = {top_row[15:0], col_c, wpos};

  // Heap helpers.
  logic [CW:0]   c_idx, c_idx_p1, sc_p1;
  logic [CW-1:0] hk_m1;
  logic          pick_b;
  logic [31:0]   sel_val;

  assign c_idx    = {si, 1'b1};
  assign c_idx_p1 = c_idx + (CW+1)'(1);
  assign sc_p1    = sc + (CW+1)'(1);
  assign hk_m1    = hk - CW'(1);
  assign pick_b   = (sc_p1 < {1'b0, hn}) && (rd_b > rd_a);
  assign sel_val  = pick_b ? rd_b : rd_a;

  // Row scan helpers.
  logic               new_row;
  logic signed [CW:0] wbase, wnew;
  logic [14:0]        lbase, lnew;
  logic               found;

  assign new_row = !have_row || (rd_a[31:16] != scan_row);
  assign wbase   = new_row ? '0 : wsum;
  assign lbase   = new_row ? '0 : left_col;
  assign lnew    = (wbase == '0) ? rd_a[15:1] : lbase;
  assign wnew    = rd_a[0] ? (wbase + (CW+1)'(1)) : (wbase - (CW+1)'(1));
  assign found   = (wnew == '0) && (rd_a[15:1] > lnew);

  // Atom store port control.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = si[AIW-1:0];
    wr_data   = sv;
    rd_addr_a = '0;
    rd_addr_b = '0;
    unique case (state)
      M_ROW: begin
        if (top_row < bot_row && count < FULL) begin
          wr_en   = 1'b1;
          wr_addr = count[AIW-1:0];
          wr_data = atom_new;
        end
      end
      S_BLOOP: rd_addr_a = hk_m1[AIW-1:0];
      S_SIFT: begin
        if (c_idx >= {1'b0, hn}) begin
          wr_en = 1'b1;
        end else begin
          rd_addr_a = c_idx[AIW-1:0];
          rd_addr_b = c_idx_p1[AIW-1:0];
        end
      end
      S_SRD: begin
        wr_en   = 1'b1;
        wr_data = (sv >= sel_val) ? sv : sel_val;
      end
      S_XLOOP: rd_addr_b = hk_m1[AIW-1:0];
      S_XRD: begin
        wr_en   = 1'b1;
        wr_addr = hk_m1[AIW-1:0];
        wr_data = rd_a;
      end
      S_SCAN: rd_addr_a = si[AIW-1:0];
      default: ;
    endcase
  end

  cmd_t cmd;
  assign cmd = cmd_t'(s_axis_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ret           <= ST_IDLE;
      clip_left     <= '0;
      clip_right    <= '0;
      clip_top      <= '0;
      clip_bottom   <= '0;
      first_px      <= '0;
      first_py      <= '0;
      prev_px       <= '0;
      prev_py       <= '0;
      awaiting_move <= 1'b1;
      count         <= '0;
      ovf           <= 1'b0;
      m_valid       <= 1'b0;
      md_ctrl       <= '0;
    end else begin
      md_ctrl.start <= 1'b0;
      if (m_valid && m_axis_tready) m_valid <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CLIP_LEFT:   clip_left   <= cfg_data[14:0];
          REG_CLIP_RIGHT:  clip_right  <= cfg_data[14:0];
          REG_CLIP_TOP:    clip_top    <= cfg_data;
          REG_CLIP_BOTTOM: clip_bottom <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            unique case (cmd)
              CMD_MOVE: begin
                first_px      <= s_axis_tdata[23:0];
                first_py      <= s_axis_tdata[47:24];
                prev_px       <= s_axis_tdata[23:0];
                prev_py       <= s_axis_tdata[47:24];
                awaiting_move <= 1'b0;
              end
              CMD_LINE: begin
                if (!awaiting_move) begin
                  x0      <= ARITH_W'(prev_px);
                  y0      <= ARITH_W'(prev_py);
                  x1      <= ARITH_W'(signed'(s_axis_tdata[23:0]));
                  y1      <= ARITH_W'(signed'(s_axis_tdata[47:24]));
                  prev_px <= s_axis_tdata[23:0];
                  prev_py <= s_axis_tdata[47:24];
                  wpos    <= 1'b1;
                  state   <= A_ORDER;
                end
              end
              CMD_CLOSE: begin
                if (!awaiting_move) begin
                  x0            <= ARITH_W'(prev_px);
                  y0            <= ARITH_W'(prev_py);
                  x1            <= ARITH_W'(first_px);
                  y1            <= ARITH_W'(first_py);
                  wpos          <= 1'b1;
                  awaiting_move <= 1'b1;
                  state         <= A_ORDER;
                end
              end
              CMD_TEST: begin
                hk    <= count >> 1;
                state <= S_BLOOP;
              end
              default: ;
            endcase
          end
        end

        // ---------------- edge clipping ----------------
        A_ORDER: begin
          if (y0 == y1) begin
            state <= ST_IDLE;
          end else begin
            if (y0 > y1) begin
              x0   <= x1;
              x1   <= x0;
              y0   <= y1;
              y1   <= y0;
              wpos <= 1'b0;
            end
            state <= A_VCHK;
          end
        end
        A_VCHK: begin
          nx0 <= x0;
          nx1 <= x1;
          if (clip_top >= clip_bottom || y1 <= lim_t || y0 >= lim_b) begin
            state <= ST_IDLE;
          end else if (y0 < lim_t) begin
            md_ctrl <= '{start: 1'b1, op: MD_MUL};
            md_a    <= x1 - x0;
            md_b    <= lim_t - y0;
            state   <= A_TMUL;
          end else if (y1 > lim_b) begin
            md_ctrl <= '{start: 1'b1, op: MD_MUL};
            md_a    <= x1 - x0;
            md_b    <= lim_b - y1;
            state   <= A_BMUL;
          end else begin
            state <= A_XORD;
          end
        end
        A_TMUL: begin
          if (md_stat.done) begin
            md_ctrl <= '{start: 1'b1, op: MD_DIVF};
            md_a    <= md_res;
            md_b    <= y1 - y0;
            state   <= A_TDIV;
          end
        end
        A_TDIV: begin
          if (md_stat.done) begin
            nx0 <= x0 + md_res;
            if (y1 > lim_b) begin
              md_ctrl <= '{start: 1'b1, op: MD_MUL};
              md_a    <= x1 - x0;
              md_b    <= lim_b - y1;
              state   <= A_BMUL;
            end else begin
              state <= A_COMMIT;
            end
          end
        end
        A_BMUL: begin
          if (md_stat.done) begin
            md_ctrl <= '{start: 1'b1, op: MD_DIVF};
            md_a    <= md_res;
            md_b    <= y1 - y0;
            state   <= A_BDIV;
          end
        end
        A_BDIV: begin
          if (md_stat.done) begin
            nx1   <= x1 + md_res;
            state <= A_COMMIT;
          end
        end
        A_COMMIT: begin
          x0 <= nx0;
          x1 <= nx1;
          if (y0 < lim_t) y0 <= lim_t;
          if (y1 > lim_b) y1 <= lim_b;
          state <= A_XORD;
        end
        A_XORD: begin
          if (x0 > x1) begin
            x0   <= x1;
            x1   <= x0;
            y0   <= y1;
            y1   <= y0;
            wpos <= ~wpos;
          end
          state <= A_HCHK;
        end
        A_HCHK: begin
          if (x1 <= lim_l) begin
            // Wholly left of the clip: one vertical edge on the left side.
            ax0   <= lim_l;
            ay0   <= y0;
            ax1   <= lim_l;
            ay1   <= y1;
            ret   <= ST_IDLE;
            state <= M_START;
          end else if (x0 >= lim_r) begin
            ax0   <= lim_r;
            ay0   <= y0;
            ax1   <= lim_r;
            ay1   <= y1;
            ret   <= ST_IDLE;
            state <= M_START;
          end else if (x0 < lim_l) begin
            md_ctrl <= '{start: 1'b1, op: MD_MUL};
            md_a    <= lim_l - x0;
            md_b    <= y1 - y0;
            state   <= A_LMUL;
          end else begin
            state <= A_RCHK;
          end
        end
        A_LMUL: begin
          if (md_stat.done) begin
            md_ctrl <= '{start: 1'b1, op: MD_DIVF};
            md_a    <= md_res;
            md_b    <= x1 - x0;
            state   <= A_LDIV;
          end
        end
        A_LDIV: begin
          if (md_stat.done) begin
            ys    <= y0 + md_res;
            ax0   <= lim_l;
            ay0   <= y0;
            ax1   <= lim_l;
            ay1   <= y0 + md_res;
            ret   <= A_LPOST;
            state <= M_START;
          end
        end
        A_LPOST: begin
          x0    <= lim_l;
          y0    <= ys;
          state <= A_RCHK;
        end
        A_RCHK: begin
          if (x1 > lim_r) begin
            md_ctrl <= '{start: 1'b1, op: MD_MUL};
            md_a    <= lim_r - x0;
            md_b    <= y1 - y0;
            state   <= A_RMUL;
          end else begin
            ax0   <= x0;
            ay0   <= y0;
            ax1   <= x1;
            ay1   <= y1;
            ret   <= ST_IDLE;
            state <= M_START;
          end
        end
        A_RMUL: begin
          if (md_stat.done) begin
            md_ctrl <= '{start: 1'b1, op: MD_DIVF};
            md_a    <= md_res;
            md_b    <= x1 - x0;
            state   <= A_RDIV;
          end
        end
        A_RDIV: begin
          if (md_stat.done) begin
            ys    <= y0 + md_res;
            ax0   <= lim_r;
            ay0   <= y0 + md_res;
            ax1   <= lim_r;
            ay1   <= y1;
            ret   <= A_RPOST;
            state <= M_START;
          end
        end
        A_RPOST: begin
          ax0   <= x0;
          ay0   <= y0;
          ax1   <= lim_r;
          ay1   <= ys;
          ret   <= ST_IDLE;
          state <= M_START;
        end

        // ---------------- segment stepping ----------------
        M_START: begin
          if (rt == rb) begin
            state <= ret;
          end else begin
            top_row <= (rt < rb) ? rt : rb;
            bot_row <= (rt < rb) ? rb : rt;
            md_ctrl <= '{start: 1'b1, op: MD_DIVT};
            md_a    <= (ax1 - ax0) <<< 16;
            md_b    <= ay1 - ay0;
            state   <= M_SLOPE;
          end
        end
        M_SLOPE: begin
          if (md_stat.done) begin
            if (md_res > SLOPE_MAX) begin
              slope <= 32'sh7FFF_FFFF;
            end else if (md_res < SLOPE_MIN) begin
              slope <= 32'sh8000_0000;
            end else begin
              slope <= md_res[31:0];
            end
            state <= M_FACT;
          end
        end
        M_FACT: begin
          md_ctrl <= '{start: 1'b1, op: MD_MUL};
          md_a    <= slope_ext;
          md_b    <= (top_row <<< (FRAC_BITS + 1)) - (ay0 <<< 1) + ONE_PX;
          state   <= M_PROD;
        end
        M_PROD: begin
          if (md_stat.done) begin
            xq    <= (ax0 <<< (16 - FRAC_BITS)) + (md_res >>> (FRAC_BITS + 1)) + XQ_HALF;
            state <= M_ROW;
          end
        end
        M_ROW: begin
          if (top_row >= bot_row) begin
            state <= ret;
          end else if (count >= FULL) begin
            // Store full: the rest of this segment is dropped as well.
            ovf   <= 1'b1;
            state <= ret;
          end else begin
            count   <= count + CW'(1);
            xq      <= xq + slope_ext;
            top_row <= top_row + ARITH_W'(1);
          end
        end

        // ---------------- heap sort ----------------
        S_BLOOP: begin
          if (hk == '0) begin
            hk    <= count;
            state <= S_XLOOP;
          end else begin
            si    <= hk_m1;
            hn    <= count;
            hk    <= hk_m1;
            ret   <= S_BLOOP;
            state <= S_BRD;
          end
        end
        S_BRD: begin
          sv    <= rd_a;
          state <= S_SIFT;
        end
        S_SIFT: begin
          if (c_idx >= {1'b0, hn}) begin
            state <= ret;
          end else begin
            sc    <= c_idx;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          if (sv >= sel_val) begin
            state <= ret;
          end else begin
            si    <= pick_b ? sc_p1[CW-1:0] : sc[CW-1:0];
            state <= S_SIFT;
          end
        end
        S_XLOOP: begin
          if (hk <= CW'(1)) begin
            si       <= '0;
            have_row <= 1'b0;
            state    <= S_SCAN;
          end else begin
            state <= S_XRD;
          end
        end
        S_XRD: begin
          sv    <= rd_b;
          si    <= '0;
          hn    <= hk_m1;
          hk    <= hk_m1;
          ret   <= S_XLOOP;
          state <= S_SIFT;
        end

        // ---------------- winding scan ----------------
        S_SCAN: begin
          if (si >= count) begin
            hit_flag <= 1'b0;
            state    <= S_DONE;
          end else begin
            state <= S_SCN2;
          end
        end
        S_SCN2: begin
          if (found) begin
            hit_flag <= 1'b1;
            state    <= S_DONE;
          end else begin
            have_row <= 1'b1;
            scan_row <= rd_a[31:16];
            wsum     <= wnew;
            left_col <= lnew;
            si       <= si + CW'(1);
            state    <= S_SCAN;
          end
        end
        S_DONE: begin
          if (!m_valid || m_axis_tready) begin
            m_valid       <= 1'b1;
            m_hit         <= hit_flag;
            m_ovf         <= ovf;
            count         <= '0;
            ovf           <= 1'b0;
            awaiting_move <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {6'b0, m_ovf, m_hit};

endmodule

[rtl/pcht_muldiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcht_muldiv
// Shared bit-serial signed multiplier and divider (floor or truncating).
// ----------------------------------------------------------------------------
module pcht_muldiv
  import pcht_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  md_ctrl_t                  ctrl,
  input  logic signed [ARITH_W-1:0] a,
  input  logic signed [ARITH_W-1:0] b,
  output md_stat_t                  stat
);

  localparam int CNT_W = $clog2(ARITH_W);

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_FIX
  } md_state_t;

  md_state_t            state;
  md_op_t               op;
  logic                 neg;
  logic [ARITH_W-1:0]   acc;
  logic [ARITH_W-1:0]   rem;
  logic [ARITH_W-1:0]   sh;
  logic [ARITH_W-1:0]   src;
  logic [CNT_W-1:0]     cnt;
  logic signed [ARITH_W-1:0] result;
  logic                 done;

  logic [ARITH_W-1:0]   abs_a;
  logic [ARITH_W-1:0]   abs_b;
  logic [ARITH_W:0]     rem_sh;
  logic                 fits;

  assign abs_a  = a[ARITH_W-1] ? ARITH_W'(-a) : ARITH_W'(a);
  assign abs_b  = b[ARITH_W-1] ? ARITH_W'(-b) : ARITH_W'(b);
  assign rem_sh = {rem, src[ARITH_W-1]};
  assign fits   = rem_sh >= {1'b0, sh};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        MD_IDLE: begin
          if (ctrl.start) begin
            op  <= ctrl.op;
            neg <= a[ARITH_W-1] ^ b[ARITH_W-1];
            acc <= '0;
            rem <= '0;
            cnt <= '0;
            if (ctrl.op == MD_MUL) begin
              sh  <= abs_a;
              src <= abs_b;
            end else begin
              sh  <= abs_b;
              src <= abs_a;
            end
            state <= MD_RUN;
          end
        end
        MD_RUN: begin
          if (op == MD_MUL) begin
            // Shift-and-add; stops once no multiplier bits are left.
            if (src[0]) acc <= acc + sh;
            sh  <= sh << 1;
            src <= src >> 1;
            if (src[ARITH_W-1:1] == '0) state <= MD_FIX;
          end else begin
            // Restoring division, one quotient bit per cycle.
            rem <= fits ? ARITH_W'(rem_sh - {1'b0, sh}) : rem_sh[ARITH_W-1:0];
            acc <= {acc[ARITH_W-2:0], fits};
            src <= src << 1;
            cnt <= cnt + CNT_W'(1);
            if (cnt == CNT_W'(ARITH_W - 1)) state <= MD_FIX;
          end
        end
        MD_FIX: begin
          if (op == MD_DIVF && neg && rem != '0) begin
            result <= ~acc;
          end else if (neg) begin
            result <= -acc;
          end else begin
            result <= acc;
          end
          done  <= 1'b1;
          state <= MD_IDLE;
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

  assign stat.done   = done;
  assign stat.result = result;

endmodule

[bench/path_coverage_hit_test_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_coverage_hit_test_unit_test
// Self-checking bench for the nonzero-winding path hit test unit.
// ----------------------------------------------------------------------------
// Path commands are fed from a queue of pending requests by a clocked driver.
// Each accepted command also updates a local model of the unit, which queues
// the expected hit and overflow flags for every run test. A clocked monitor
// compares each result request with the oldest expectation. The clip
// rectangle is reprogrammed between phases, only once the unit is idle.
// ----------------------------------------------------------------------------
module path_coverage_hit_test_unit_test;
  import pcht_pkg::*;

  localparam int ATOM_DEPTH = 4096;
  localparam int FRAC = 8;
  localparam int ONE_PX = 1 << FRAC;

  typedef enum logic [1:0] {
    CMD_MOVE,
    CMD_LINE,
    CMD_CLOSE,
    CMD_TEST
  } path_cmd_t;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT,
    REG_CLIP_RIGHT,
    REG_CLIP_TOP,
    REG_CLIP_BOTTOM
  } clip_reg_t;

  typedef struct {
    path_cmd_t          cmd;
    logic signed [23:0] px;
    logic signed [23:0] py;
  } path_req_t;

  typedef struct {
    logic hit;
    logic ovf;
  } hit_flags_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  path_coverage_hit_test_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Bench-side view of the unit's state.
  int unsigned clip_l, clip_r, clip_t, clip_b;
  longint      start_x, start_y, pen_x, pen_y;
  bit          need_move;
  bit          store_ovf;
  bit [31:0]   atoms[$];

  path_req_t  pending_cmds[$];
  hit_flags_t expected_flags[$];

  int  errors;
  int  cmds_sent;
  int  results_seen;
  int  hits_seen;
  int  ovfs_seen;
  bit  idling_on;
  bit  hold_go;
  bit  hold_active;
  int  send_gap;
  int  recv_gap;

  // --------------------------------------------------------------------------
  // Hit test model.
  // --------------------------------------------------------------------------
  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint nearest_row(longint y);
    return floor_div(y + ONE_PX / 2, ONE_PX);
  endfunction

  function automatic longint right_edge();
    return (clip_r < clip_l) ? longint'(clip_l) : longint'(clip_r);
  endfunction

  function automatic void store_atom(longint row, longint col, int w);
    bit [15:0] r;
    bit [14:0] c;
    if (atoms.size() >= ATOM_DEPTH) begin
      store_ovf = 1'b1;
      return;
    end
    r = row[15:0];
    c = col[14:0];
    atoms.push_back({r, c, (w > 0) ? 1'b1 : 1'b0});
  endfunction

  // Step one clipped segment down its pixel rows.
  function automatic void trace_rows(longint x0, longint y0, longint x1, longint y1,
                                     int w);
    longint top, bot, slope, xq, row, col, lo, hi, t;
    top = nearest_row(y0);
    bot = nearest_row(y1);
    lo = clip_l;
    hi = right_edge();
    if (top == bot) return;
    if (top > bot) begin
      t = top; top = bot; bot = t;
    end
    slope = ((x1 - x0) * 65536) / (y1 - y0);
    if (slope > 64'sd2147483647) slope = 64'sd2147483647;
    if (slope < -64'sd2147483648) slope = -64'sd2147483648;
    xq = x0 * (1 << (16 - FRAC))
       + floor_div(slope * (2 * top * ONE_PX - 2 * y0 + ONE_PX), 1 << (FRAC + 1))
       + 32768;
    for (row = top; row < bot; row++) begin
      col = floor_div(xq, 65536);
      if (col < lo) col = lo;
      if (col > hi) col = hi;
      store_atom(row, col, w);
      xq += slope;
    end
  endfunction

  // Clip one path segment to the rectangle and trace the pieces.
  function automatic void clip_segment(longint x0, longint y0, longint x1, longint y1);
    int     w;
    longint tp, bt, lx, rx, t, y, dx, dy, nx0, ny0, nx1, ny1;
    w = 1;
    if (y0 == y1) return;
    if (y0 > y1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
      w = -1;
    end
    if (clip_t >= clip_b) return;
    tp = longint'(clip_t) * ONE_PX;
    bt = longint'(clip_b) * ONE_PX;
    if (y1 <= tp || y0 >= bt) return;
    dx = x1 - x0;
    dy = y1 - y0;
    nx0 = x0; ny0 = y0; nx1 = x1; ny1 = y1;
    if (y0 < tp) begin
      nx0 = x0 + floor_div(dx * (tp - y0), dy);
      ny0 = tp;
    end
    if (y1 > bt) begin
      nx1 = x1 + floor_div(dx * (bt - y1), dy);
      ny1 = bt;
    end
    x0 = nx0; y0 = ny0; x1 = nx1; y1 = ny1;
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
      w = -w;
    end
    lx = longint'(clip_l) * ONE_PX;
    rx = right_edge() * ONE_PX;
    // A segment wholly outside on one side collapses onto that clip side.
    if (x1 <= lx) begin
      trace_rows(lx, y0, lx, y1, w);
      return;
    end
    if (x0 >= rx) begin
      trace_rows(rx, y0, rx, y1, w);
      return;
    end
    if (x0 < lx) begin
      y = y0 + floor_div((lx - x0) * (y1 - y0), x1 - x0);
      trace_rows(lx, y0, lx, y, w);
      x0 = lx; y0 = y;
    end
    if (x1 > rx) begin
      y = y0 + floor_div((rx - x0) * (y1 - y0), x1 - x0);
      trace_rows(rx, y, rx, y1, w);
      x1 = rx; y1 = y;
    end
    trace_rows(x0, y0, x1, y1, w);
  endfunction

  // Sort the atoms and look for a closed run of nonzero winding.
  function automatic bit winding_hit();
    int        i, n, wsum, left, x;
    bit [15:0] row;
    atoms.sort();
    n = atoms.size();
    i = 0;
    while (i < n) begin
      row = atoms[i][31:16];
      wsum = 0;
      left = 0;
      while (i < n && atoms[i][31:16] == row) begin
        x = atoms[i][15:1];
        if (wsum == 0) left = x;
        wsum += atoms[i][0] ? 1 : -1;
        if (wsum == 0 && x > left) return 1'b1;
        i++;
      end
    end
    return 1'b0;
  endfunction

  function automatic void apply_cmd(path_req_t r);
    hit_flags_t f;
    longint     px, py;
    px = r.px;
    py = r.py;
    case (r.cmd)
      CMD_MOVE: begin
        start_x = px; start_y = py;
        pen_x = px; pen_y = py;
        need_move = 1'b0;
      end
      CMD_LINE: begin
        if (!need_move) begin
          clip_segment(pen_x, pen_y, px, py);
          pen_x = px; pen_y = py;
        end
      end
      CMD_CLOSE: begin
        // Close adds the edge back to the start; the pen stays where it is.
        if (!need_move) begin
          clip_segment(pen_x, pen_y, start_x, start_y);
          need_move = 1'b1;
        end
      end
      default: begin
        f.hit = winding_hit();
        f.ovf = store_ovf;
        expected_flags.push_back(f);
        atoms.delete();
        store_ovf = 1'b0;
        need_move = 1'b1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Command driver.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    path_req_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        nxt.cmd = path_cmd_t'(s_axis_tuser);
        nxt.px = s_axis_tdata[23:0];
        nxt.py = s_axis_tdata[47:24];
        apply_cmd(nxt);
        cmds_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {nxt.py, nxt.px};
          s_axis_tuser <= nxt.cmd;
          if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    hit_flags_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_flags.size() == 0) begin
          report_mismatch("unexpected result, flags", m_axis_tdata, 0);
        end else begin
          want = expected_flags.pop_front();
          if (m_axis_tdata[0] !== want.hit) report_mismatch("hit", m_axis_tdata[0], want.hit);
          if (m_axis_tdata[1] !== want.ovf) report_mismatch("overflow", m_axis_tdata[1], want.ovf);
          if (m_axis_tdata[7:2] !== 6'd0) report_mismatch("padding", m_axis_tdata[7:2], 0);
          hits_seen += want.hit;
          ovfs_seen += want.ovf;
        end
        results_seen++;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !hold_active;
      end
    end
  end

  // Long hold-off on the result side, so tests back up into the command stream.
  always @(posedge clk) begin
    if (rst) begin
      hold_active <= 1'b0;
    end else if (hold_go && !hold_active) begin
      hold_active <= 1'b1;
      repeat (4000) @(posedge clk);
      hold_active <= 1'b0;
      hold_go = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  task automatic write_reg(input clip_reg_t idx, input int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CLIP_LEFT:  clip_l = value & 32'h7FFF;
      REG_CLIP_RIGHT: clip_r = value & 32'h7FFF;
      REG_CLIP_TOP:   clip_t = value & 32'hFFFF;
      default:        clip_b = value & 32'hFFFF;
    endcase
  endtask

  task automatic set_clip(input int unsigned l, r, t, b);
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_RIGHT, r);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_BOTTOM, b);
  endtask

  function automatic void queue_cmd(path_cmd_t c, longint x, longint y);
    path_req_t r;
    r.cmd = c;
    r.px = x[23:0];
    r.py = y[23:0];
    pending_cmds.push_back(r);
  endfunction

  // A point mostly near the clip, sometimes anywhere in the coordinate range.
  function automatic longint near_coord(int unsigned lo, int unsigned span);
    longint pix, frac;
    if ($urandom_range(0, 9) == 0) return longint'($signed(24'($urandom)));
    pix = longint'(lo) - 3 + $urandom_range(0, span + 6);
    case ($urandom_range(0, 3))
      0:       frac = 0;
      1:       frac = ONE_PX / 2;
      default: frac = $urandom_range(0, ONE_PX - 1);
    endcase
    return pix * ONE_PX + frac;
  endfunction

  function automatic void queue_contours(int n_cmds);
    int unsigned xs, ys;
    int          k, left;
    xs = (right_edge() - clip_l) + 1;
    ys = (clip_b > clip_t) ? clip_b - clip_t : 4;
    left = n_cmds;
    while (left > 0) begin
      if ($urandom_range(0, 7) == 0) begin
        // Noise: any command with any coordinates.
        queue_cmd(path_cmd_t'($urandom_range(0, 3)), $signed(24'($urandom)),
                  $signed(24'($urandom)));
        left--;
      end else begin
        queue_cmd(CMD_MOVE, near_coord(clip_l, xs), near_coord(clip_t, ys));
        for (k = $urandom_range(1, 5); k > 0; k--)
          queue_cmd(CMD_LINE, near_coord(clip_l, xs), near_coord(clip_t, ys));
        if ($urandom_range(0, 4) != 0) queue_cmd(CMD_CLOSE, 0, 0);
        left -= 6;
        if ($urandom_range(0, 2) == 0) begin
          queue_cmd(CMD_TEST, $urandom, $urandom);
          left--;
        end
      end
    end
    queue_cmd(CMD_TEST, 0, 0);
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_flags.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    int          ph;
    int unsigned l, r, t, b;
    errors = 0;
    cmds_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    ovfs_seen = 0;
    idling_on = 1'b1;
    hold_go = 1'b0;
    clip_l = 0; clip_r = 0; clip_t = 0; clip_b = 0;
    start_x = 0; start_y = 0; pen_x = 0; pen_y = 0;
    need_move = 1'b1;
    store_ovf = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset clip, then with a small square clip.
    queue_cmd(CMD_LINE, 100, 100);          // ignored, no move yet
    queue_cmd(CMD_CLOSE, 0, 0);             // ignored as well
    queue_cmd(CMD_TEST, 0, 0);              // empty store
    queue_cmd(CMD_MOVE, -8388608, 8388607);
    queue_cmd(CMD_MOVE, 8388607, -8388608);
    queue_cmd(CMD_TEST, 0, 0);
    drain();
    set_clip(10, 20, 10, 20);
    queue_cmd(CMD_MOVE, 12 * ONE_PX, 12 * ONE_PX);   // square inside the clip
    queue_cmd(CMD_LINE, 18 * ONE_PX, 12 * ONE_PX);   // horizontal edge
    queue_cmd(CMD_LINE, 18 * ONE_PX, 18 * ONE_PX);
    queue_cmd(CMD_LINE, 12 * ONE_PX, 18 * ONE_PX);
    queue_cmd(CMD_CLOSE, 0, 0);
    queue_cmd(CMD_TEST, 0, 0);
    queue_cmd(CMD_MOVE, 2 * ONE_PX, 0);              // left of the clip
    queue_cmd(CMD_LINE, 3 * ONE_PX, 30 * ONE_PX);
    queue_cmd(CMD_LINE, 40 * ONE_PX, 30 * ONE_PX);
    queue_cmd(CMD_LINE, 40 * ONE_PX, 0);             // right of the clip
    queue_cmd(CMD_TEST, 0, 0);                       // open contour
    queue_cmd(CMD_MOVE, 5 * ONE_PX, 5 * ONE_PX);     // spans both clip sides
    queue_cmd(CMD_LINE, 25 * ONE_PX, 25 * ONE_PX);
    queue_cmd(CMD_LINE, 5 * ONE_PX, 25 * ONE_PX);
    queue_cmd(CMD_CLOSE, 0, 0);
    queue_cmd(CMD_TEST, 0, 0);
    drain();

    // Tall clip and one very tall edge overflow the atom store.
    set_clip(0, 100, 0, 65535);
    queue_cmd(CMD_MOVE, 0, -8388608);
    queue_cmd(CMD_LINE, 25600, 8388607);
    queue_cmd(CMD_LINE, 0, 8388607);
    queue_cmd(CMD_CLOSE, 0, 0);
    queue_cmd(CMD_TEST, 0, 0);
    queue_cmd(CMD_TEST, 0, 0);                       // flag cleared again
    drain();

    // Random phases, with extreme clips among the settings.
    for (ph = 0; ph < 28; ph++) begin
      l = $urandom_range(0, 200);
      r = l + $urandom_range(0, 40);
      t = $urandom_range(0, 200);
      b = t + $urandom_range(1, 24);
      case (ph % 7)
        1: r = (l > 0) ? l - 1 : 0;                  // inverted horizontal clip
        2: b = t;                                    // empty vertical clip
        3: begin
          l = 32760; r = 32767;
        end
        4: begin
          l = 0; r = 32767; t = 0; b = 12;
        end
        5: begin
          t = 65520; b = 65535;
        end
        default: ;
      endcase
      if (ph >= 25) idling_on = 1'b0;
      set_clip(l, r, t, b);
      if (ph == 2) hold_go = 1'b1;
      queue_contours(55);
      drain();
    end

    repeat (500) @(posedge clk);
    $display("Ran %0d commands over 31 clip settings: %0d tests, %0d hits, %0d overflows.",
             cmds_sent, results_seen, hits_seen, ovfs_seen);
    if (errors == 0 && expected_flags.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timeout with %0d results outstanding.", expected_flags.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
